[src/bqrf_pkg.sv]
// bqrf_pkg: shared constants and types for the quadratic bezier root finder
// no dependencies
`timescale 1ns / 1ps

package bqrf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_WIDTH       = 32;

    // which root formula applies to an item
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_QUAD   = 2'd2
    } kind_t;

endpackage

[src/bezier_quadratic_root_finder_top.sv]
// bezier_quadratic_root_finder_top: pipelined root finder for quadratic bezier functions
// depends on bqrf_pkg (constants, kind_t)
`timescale 1ns / 1ps

// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  ctrl_p0, ctrl_p1, ctrl_p2, interval_low, interval_high
// m_       out        m_valid / m_ready  root_count, root_first, root_second
//
// one transfer per cycle in each direction while m_valid is low or m_ready is high; the pipeline
// holds bit-serial square root and long division stages
// one pipeline stage per square root bit ((DATA_WIDTH+FRAC_BITS)/2) and per quotient bit
// (DATA_WIDTH+1+FRAC_BITS)
// aresetn is synchronous, active low, and clears all valid bits
// a stalled result holds every stage in place; nothing is dropped or repeated

module bezier_quadratic_root_finder_top #(
    parameter int DATA_WIDTH = bqrf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = bqrf_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [bqrf_pkg::IO_WIDTH-1:0] s_ctrl_p0,
    input  logic signed [bqrf_pkg::IO_WIDTH-1:0] s_ctrl_p1,
    input  logic signed [bqrf_pkg::IO_WIDTH-1:0] s_ctrl_p2,
    input  logic signed [bqrf_pkg::IO_WIDTH-1:0] s_interval_low,
    input  logic signed [bqrf_pkg::IO_WIDTH-1:0] s_interval_high,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [1:0]                    m_root_count,
    output logic signed [bqrf_pkg::IO_WIDTH-1:0] m_root_first,
    output logic signed [bqrf_pkg::IO_WIDTH-1:0] m_root_second
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int IOW = bqrf_pkg::IO_WIDTH;
    localparam int XW  = ((W > IOW) ? W : IOW) + 3;
    localparam int XN  = W + 2;
    localparam int YN  = W + 1;
    localparam int SQ  = (W + F) / 2;
    localparam int NB  = W + 1 + F;

    localparam logic signed [XW-1:0] MAXX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINX = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] LIMP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIMN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] bh;
        logic signed [W-1:0] c;
        logic signed [W-1:0] span;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        bqrf_pkg::kind_t     kind;
    } meta_t;

    typedef struct packed {
        meta_t           m;
        logic [2*SQ-1:0] rad;
        logic [SQ+1:0]   rem;
        logic [SQ-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [NB-1:0]       nq1;
        logic [NB-1:0]       nq2;
        logic [W:0]          r1;
        logic [W:0]          r2;
        logic [W:0]          uy;
        logic                n1;
        logic                n2;
        logic signed [W-1:0] span;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        bqrf_pkg::kind_t     kind;
    } dv_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        if (v > MAXX) begin
            return MAXX[W-1:0];
        end else if (v < MINX) begin
            return MINX[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] x,
                                                 input logic signed [W-1:0] y);
        logic           neg;
        logic [W-1:0]   mx;
        logic [W-1:0]   my;
        logic [2*W-1:0] pr;
        logic [2*W-1:0] sh;
        logic [W-1:0]   lim;
        logic [W-1:0]   m;
        neg = x[W-1] ^ y[W-1];
        mx  = x[W-1] ? (~x + W'(1)) : x;
        my  = y[W-1] ? (~y + W'(1)) : y;
        pr  = mx * my;
        sh  = pr >> F;
        lim = neg ? LIMN : LIMP;
        m   = (sh > {{W{1'b0}}, lim}) ? lim : sh[W-1:0];
        return $signed(neg ? (~m + W'(1)) : m);
    endfunction

    function automatic logic signed [W-1:0] clamp_q(input logic [NB-1:0] q, input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] m;
        lim = neg ? LIMN : LIMP;
        m   = (q > {{(NB-W){1'b0}}, lim}) ? lim : q[W-1:0];
        return $signed(neg ? (~m + W'(1)) : m);
    endfunction

    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // stage 1: saturate inputs, power-basis coefficients
    logic                s1_vld_reg;
    meta_t               s1_reg;
    meta_t               s1_next;
    logic signed [W-1:0] p0_in;
    logic signed [W-1:0] p1_in;
    logic signed [W-1:0] p2_in;

    always_comb begin
        p0_in        = sat_w(XW'(s_ctrl_p0));
        p1_in        = sat_w(XW'(s_ctrl_p1));
        p2_in        = sat_w(XW'(s_ctrl_p2));
        s1_next.lo   = sat_w(XW'(s_interval_low));
        s1_next.hi   = sat_w(XW'(s_interval_high));
        s1_next.a    = sat_w(XW'(p0_in) - (XW'(p1_in) <<< 1) + XW'(p2_in));
        s1_next.bh   = sat_w(XW'(p1_in) - XW'(p0_in));
        s1_next.c    = p0_in;
        s1_next.span = sat_w(XW'(s1_next.hi) - XW'(s1_next.lo));
        s1_next.kind = bqrf_pkg::KIND_NONE;
    end

    // stage 2: discriminant products
    logic                s2_vld_reg;
    meta_t               s2_reg;
    logic signed [W-1:0] pbb_reg;
    logic signed [W-1:0] pac_reg;

    // stage 3: discriminant and case selection
    logic                s3_vld_reg;
    meta_t               s3_reg;
    meta_t               s3_next;
    logic signed [W-1:0] d_reg;
    logic signed [W-1:0] d_next;

    always_comb begin
        d_next  = sat_w(XW'(pbb_reg) - XW'(pac_reg));
        s3_next = s2_reg;
        if (s2_reg.a == '0) begin
            s3_next.kind = (s2_reg.bh != '0) ? bqrf_pkg::KIND_LINEAR : bqrf_pkg::KIND_NONE;
        end else begin
            s3_next.kind = d_next[W-1] ? bqrf_pkg::KIND_NONE : bqrf_pkg::KIND_QUAD;
        end
    end

    // square root, one result bit per stage
    logic [SQ-1:0] sq_vld_reg;
    sq_t           sq_reg  [SQ];
    sq_t           sq_next [SQ];

    always_comb begin
        sq_t           src;
        logic [SQ+2:0] acc;
        logic [SQ+2:0] trial;
        for (int k = 0; k < SQ; k++) begin
            if (k == 0) begin
                src.m    = s3_reg;
                src.rad  = (2*SQ)'({d_reg[W-2:0], {F{1'b0}}});
                src.rem  = '0;
                src.root = '0;
            end else begin
                src = sq_reg[k-1];
            end
            acc   = {src.rem[SQ:0], src.rad[2*SQ-1 -: 2]};
            trial = {1'b0, src.root, 2'b01};
            sq_next[k].m   = src.m;
            sq_next[k].rad = {src.rad[2*SQ-3:0], 2'b00};
            if (acc >= trial) begin
                sq_next[k].rem  = (SQ+2)'(acc - trial);
                sq_next[k].root = {src.root[SQ-2:0], 1'b1};
            end else begin
                sq_next[k].rem  = acc[SQ+1:0];
                sq_next[k].root = {src.root[SQ-2:0], 1'b0};
            end
        end
    end

    // numerators and divisor
    logic                 x_vld_reg;
    dv_t                  x_reg;
    dv_t                  x_next;
    meta_t                xm;
    logic signed [W-1:0]  s_root;
    logic signed [XN-1:0] x1;
    logic signed [XN-1:0] x2;
    logic signed [YN-1:0] y;
    logic signed [XN-1:0] ax1;
    logic signed [XN-1:0] ax2;
    logic signed [YN-1:0] ay;

    always_comb begin
        xm     = sq_reg[SQ-1].m;
        s_root = sat_w(XW'(sq_reg[SQ-1].root));
        if (xm.kind == bqrf_pkg::KIND_LINEAR) begin
            x1 = -XN'(xm.c);
            y  = YN'(xm.bh) <<< 1;
        end else begin
            x1 = -XN'(xm.bh) - XN'(s_root);
            y  = YN'(xm.a);
        end
        x2          = -XN'(xm.bh) + XN'(s_root);
        ax1         = x1[XN-1] ? -x1 : x1;
        ax2         = x2[XN-1] ? -x2 : x2;
        ay          = y[YN-1] ? -y : y;
        x_next.nq1  = {ax1[W:0], {F{1'b0}}};
        x_next.nq2  = {ax2[W:0], {F{1'b0}}};
        x_next.r1   = '0;
        x_next.r2   = '0;
        x_next.uy   = ay;
        x_next.n1   = x1[XN-1] ^ y[YN-1];
        x_next.n2   = x2[XN-1] ^ y[YN-1];
        x_next.span = xm.span;
        x_next.lo   = xm.lo;
        x_next.hi   = xm.hi;
        x_next.kind = xm.kind;
    end

    // long division, one quotient bit per stage for both roots
    logic [NB-1:0] dv_vld_reg;
    dv_t           dv_reg  [NB];
    dv_t           dv_next [NB];

    always_comb begin
        dv_t          src;
        logic [W+1:0] acc1;
        logic [W+1:0] acc2;
        logic         q1;
        logic         q2;
        for (int k = 0; k < NB; k++) begin
            src  = (k == 0) ? x_reg : dv_reg[k-1];
            acc1 = {src.r1, src.nq1[NB-1]};
            acc2 = {src.r2, src.nq2[NB-1]};
            q1   = acc1 >= {1'b0, src.uy};
            q2   = acc2 >= {1'b0, src.uy};
            dv_next[k]     = src;
            dv_next[k].r1  = q1 ? (W+1)'(acc1 - {1'b0, src.uy}) : acc1[W:0];
            dv_next[k].r2  = q2 ? (W+1)'(acc2 - {1'b0, src.uy}) : acc2[W:0];
            dv_next[k].nq1 = {src.nq1[NB-2:0], q1};
            dv_next[k].nq2 = {src.nq2[NB-2:0], q2};
        end
    end

    // quotient clamp, scale by span, offset by low
    logic                t_vld_reg;
    logic signed [W-1:0] t1_reg;
    logic signed [W-1:0] t2_reg;
    logic signed [W-1:0] t_span_reg;
    logic signed [W-1:0] t_lo_reg;
    logic signed [W-1:0] t_hi_reg;
    bqrf_pkg::kind_t     t_kind_reg;

    logic                mu_vld_reg;
    logic signed [W-1:0] mu1_reg;
    logic signed [W-1:0] mu2_reg;
    logic signed [W-1:0] mu_lo_reg;
    logic signed [W-1:0] mu_hi_reg;
    bqrf_pkg::kind_t     mu_kind_reg;

    logic                ad_vld_reg;
    logic signed [W-1:0] ad1_reg;
    logic signed [W-1:0] ad2_reg;
    logic signed [W-1:0] ad_lo_reg;
    logic signed [W-1:0] ad_hi_reg;
    bqrf_pkg::kind_t     ad_kind_reg;

    // ordering and interval test
    logic                  out_vld_reg;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic signed [IOW-1:0] first_reg;
    logic signed [IOW-1:0] first_next;
    logic signed [IOW-1:0] second_reg;
    logic signed [IOW-1:0] second_next;

    always_comb begin
        logic signed [W-1:0]  c0;
        logic signed [W-1:0]  c1;
        logic signed [W-1:0]  k0;
        logic signed [W-1:0]  k1;
        logic signed [XW-1:0] k0x;
        logic signed [XW-1:0] k1x;
        logic [1:0]           ncand;
        c0 = ad1_reg;
        c1 = ad2_reg;
        case (ad_kind_reg)
            bqrf_pkg::KIND_LINEAR: begin
                ncand = 2'd1;
            end
            bqrf_pkg::KIND_QUAD: begin
                if (ad1_reg > ad2_reg) begin
                    c0 = ad2_reg;
                    c1 = ad1_reg;
                end
                ncand = (ad1_reg == ad2_reg) ? 2'd1 : 2'd2;
            end
            default: begin
                ncand = 2'd0;
            end
        endcase
        count_next = 2'd0;
        k0         = '0;
        k1         = '0;
        if (ncand != 2'd0 && c0 >= ad_lo_reg && c0 <= ad_hi_reg) begin
            k0         = c0;
            count_next = 2'd1;
        end
        if (ncand == 2'd2 && c1 >= ad_lo_reg && c1 <= ad_hi_reg) begin
            if (count_next == 2'd0) begin
                k0 = c1;
            end else begin
                k1 = c1;
            end
            count_next = count_next + 2'd1;
        end
        k0x         = XW'(k0);
        k1x         = XW'(k1);
        first_next  = k0x[IOW-1:0];
        second_next = k1x[IOW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            sq_vld_reg  <= '0;
            x_vld_reg   <= 1'b0;
            dv_vld_reg  <= '0;
            t_vld_reg   <= 1'b0;
            mu_vld_reg  <= 1'b0;
            ad_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            sq_vld_reg  <= {sq_vld_reg[SQ-2:0], s3_vld_reg};
            x_vld_reg   <= sq_vld_reg[SQ-1];
            dv_vld_reg  <= {dv_vld_reg[NB-2:0], x_vld_reg};
            t_vld_reg   <= dv_vld_reg[NB-1];
            mu_vld_reg  <= t_vld_reg;
            ad_vld_reg  <= mu_vld_reg;
            out_vld_reg <= ad_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            pbb_reg <= fmul(s1_reg.bh, s1_reg.bh);
            pac_reg <= fmul(s1_reg.a, s1_reg.c);
            s3_reg  <= s3_next;
            d_reg   <= d_next;
            for (int k = 0; k < SQ; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            x_reg <= x_next;
            for (int k = 0; k < NB; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            t1_reg      <= clamp_q(dv_reg[NB-1].nq1, dv_reg[NB-1].n1);
            t2_reg      <= clamp_q(dv_reg[NB-1].nq2, dv_reg[NB-1].n2);
            t_span_reg  <= dv_reg[NB-1].span;
            t_lo_reg    <= dv_reg[NB-1].lo;
            t_hi_reg    <= dv_reg[NB-1].hi;
            t_kind_reg  <= dv_reg[NB-1].kind;
            mu1_reg     <= fmul(t1_reg, t_span_reg);
            mu2_reg     <= fmul(t2_reg, t_span_reg);
            mu_lo_reg   <= t_lo_reg;
            mu_hi_reg   <= t_hi_reg;
            mu_kind_reg <= t_kind_reg;
            ad1_reg     <= sat_w(XW'(mu1_reg) + XW'(mu_lo_reg));
            ad2_reg     <= sat_w(XW'(mu2_reg) + XW'(mu_lo_reg));
            ad_lo_reg   <= mu_lo_reg;
            ad_hi_reg   <= mu_hi_reg;
            ad_kind_reg <= mu_kind_reg;
            count_reg   <= count_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_root_count  = count_reg;
    assign m_root_first  = first_reg;
    assign m_root_second = second_reg;

`ifndef SYNTHESIS
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_count == 2'd0 |-> m_root_first == '0)
        else $error("first root not zero with no roots");

    a_second_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_count != 2'd2 |-> m_root_second == '0)
        else $error("second root not zero with fewer than two roots");

    a_tail_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ce |=> m_valid == $past(ad_vld_reg))
        else $error("result valid lost or invented at the output stage");
`endif

endmodule
